// File: hw/rtl/dhke_pkg.sv
// Shared types for the modular exponentiation key exchange unit.
// Holds the controller state encoding and the command and status bundles.
`timescale 1ns / 1ps

package dhke_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRIME_CHK,
        ST_PRIME_WAIT,
        ST_PRIME_NEXT,
        ST_EXP_INIT,
        ST_EXP_MUL,
        ST_EXP_WAIT,
        ST_EXP_NEXT,
        ST_DONE
    } dhke_state_t;

    typedef enum logic [1:0] {
        MOD_DIVCHK,
        MOD_ACC,
        MOD_SQ
    } mod_op_t;

    typedef struct packed {
        logic       load;
        logic       div_init;
        logic       div_start;
        logic       div_step;
        logic       exp_init;
        logic [1:0] exp_sel;
        logic       mod_start;
        mod_op_t    mod_op;
        logic       exp_shift;
        logic       save_result;
        logic       clear_result;
        logic       out_load;
    } dhke_cmd_t;

    typedef struct packed {
        logic small_p;
        logic div_over;
        logic divisible;
        logic mod_busy;
        logic exp_zero;
        logic exp_bit;
    } dhke_sts_t;

endpackage

// File: hw/rtl/dhke_modred.sv
// Sequential remainder unit: one restoring step per cycle.
// Does not use dhke_pkg; standalone arithmetic.
`timescale 1ns / 1ps

module dhke_modred #(
    parameter int W = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [2*W-1:0] dividend,
    input  logic [W-1:0]   divisor,
    output logic           busy,
    output logic [W-1:0]   rem
);

    localparam int CW = $clog2(2 * W + 1);

    logic [2*W-1:0] num_reg, num_next;
    logic [W:0]     rem_reg, rem_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic [W:0]     trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[W-1:0], num_reg[2*W-1]};
        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(2 * W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[2*W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_next = trial - {1'b0, divisor};
            else
                rem_next = trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg[W-1:0];

endmodule

// File: hw/rtl/dhke_datapath.sv
// Datapath: operand registers, trial divisor, exponent, shared multiply and remainder.
// Depends on dhke_pkg and dhke_modred.
`timescale 1ns / 1ps

module dhke_datapath #(
    parameter int W = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dhke_pkg::dhke_cmd_t cmd,
    output dhke_pkg::dhke_sts_t sts,
    input  logic [W-1:0]       generator,
    input  logic [W-1:0]       modulus,
    input  logic [W-1:0]       secret_a,
    input  logic [W-1:0]       secret_b,
    output logic [W-1:0]       public_a,
    output logic [W-1:0]       public_b,
    output logic [W-1:0]       key_one,
    output logic [W-1:0]       key_two,
    output logic               not_prime
);

    import dhke_pkg::*;

    logic [W-1:0]   g_reg, p_reg, a_reg, b_reg;
    logic [W-1:0]   d_reg;
    logic [W-1:0]   exp_reg, acc_reg, sq_reg;
    logic [W-1:0]   pa_reg, pb_reg, k1_reg, k2_reg;
    logic [W-1:0]   pa_out_reg, pb_out_reg, k1_out_reg, k2_out_reg;
    logic           np_out_reg;
    logic [1:0]     sel_reg;
    mod_op_t        op_reg;
    logic [2*W-1:0] prod;
    logic [2*W-1:0] dsq;
    logic           mod_busy;
    logic [W-1:0]   rem;
    logic [W-1:0]   base_sel, exp_sel;
    logic [W-1:0]   mul_a, mul_b;
    logic [W-1:0]   div_sel;
    logic [2*W-1:0] mod_in;

    dhke_modred #(.W(W)) u_modred (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (mod_in),
        .divisor  (div_sel),
        .busy     (mod_busy),
        .rem      (rem)
    );

    always_comb
    begin
        case (cmd.exp_sel)
            2'd0:    begin base_sel = g_reg;  exp_sel = a_reg; end
            2'd1:    begin base_sel = g_reg;  exp_sel = b_reg; end
            2'd2:    begin base_sel = pb_reg; exp_sel = a_reg; end
            default: begin base_sel = pa_reg; exp_sel = b_reg; end
        endcase
        mul_a = (cmd.mod_op == MOD_ACC) ? acc_reg : sq_reg;
        mul_b = sq_reg;
        case (cmd.mod_op)
            MOD_DIVCHK: mod_in = {{W{1'b0}}, p_reg};
            MOD_ACC:    mod_in = prod;
            MOD_SQ:     mod_in = prod;
            default:    mod_in = prod;
        endcase
    end

    assign prod    = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
    assign dsq     = {{W{1'b0}}, d_reg} * {{W{1'b0}}, d_reg};
    assign div_sel = (op_reg == MOD_DIVCHK) ? d_reg : p_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            g_reg <= generator;
            p_reg <= modulus;
            a_reg <= secret_a;
            b_reg <= secret_b;
        end
        if (cmd.div_init)
            d_reg <= W'(2);
        else if (cmd.div_step)
            d_reg <= d_reg + 1'b1;
        if (cmd.div_start)
            p_reg <= p_reg;
        if (cmd.mod_start)
            op_reg <= cmd.mod_op;
        if (cmd.exp_init)
        begin
            exp_reg <= exp_sel;
            sel_reg <= cmd.exp_sel;
            acc_reg <= W'(1);
            sq_reg  <= base_sel;
        end
        else if (cmd.save_result)
        begin
            case (sel_reg)
                2'd0:    pa_reg <= acc_reg;
                2'd1:    pb_reg <= acc_reg;
                2'd2:    k1_reg <= acc_reg;
                default: k2_reg <= acc_reg;
            endcase
        end
        else if (!mod_busy && op_reg != MOD_DIVCHK && cmd.exp_shift)
        begin
            if (op_reg == MOD_ACC)
                acc_reg <= rem;
            else
            begin
                sq_reg  <= rem;
                exp_reg <= exp_reg >> 1;
            end
        end
        else if (cmd.exp_shift && op_reg == MOD_DIVCHK)
        begin
            sq_reg <= rem;
        end
        if (cmd.out_load)
        begin
            pa_out_reg <= cmd.clear_result ? '0 : pa_reg;
            pb_out_reg <= cmd.clear_result ? '0 : pb_reg;
            k1_out_reg <= cmd.clear_result ? '0 : k1_reg;
            k2_out_reg <= cmd.clear_result ? '0 : k2_reg;
            np_out_reg <= cmd.clear_result;
        end
    end

    always_comb
    begin
        sts.small_p   = (p_reg < W'(2));
        sts.div_over  = (dsq > {{W{1'b0}}, p_reg});
        sts.divisible = (rem == '0);
        sts.mod_busy  = mod_busy;
        sts.exp_zero  = (exp_reg == '0);
        sts.exp_bit   = exp_reg[0];
    end

    assign public_a  = pa_out_reg;
    assign public_b  = pb_out_reg;
    assign key_one   = k1_out_reg;
    assign key_two   = k2_out_reg;
    assign not_prime = np_out_reg;

endmodule

// File: hw/rtl/dhke_ctrl.sv
// Controller: sequences the primality test and four exponentiations.
// Depends on dhke_pkg.
`timescale 1ns / 1ps

module dhke_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  dhke_pkg::dhke_sts_t sts,
    output dhke_pkg::dhke_cmd_t cmd
);

    import dhke_pkg::*;

    dhke_state_t state_reg, state_next;
    logic [1:0]  idx_reg, idx_next;
    logic        sq_phase_reg, sq_phase_next;
    logic        fail_reg, fail_next;
    logic        ov_reg, ov_next;
    logic        finish;

    assign finish   = (state_reg == ST_DONE) && (!ov_reg || out_ready);
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        sq_phase_next = sq_phase_reg;
        fail_next     = fail_reg;
        ov_next       = ov_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_PRIME_CHK;
            ST_PRIME_CHK:
                if (sts.small_p)
                begin
                    fail_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.div_over)
                begin
                    fail_next  = 1'b0;
                    idx_next   = 2'd0;
                    state_next = ST_EXP_INIT;
                end
                else
                    state_next = ST_PRIME_WAIT;
            ST_PRIME_WAIT:
                if (!sts.mod_busy)
                    state_next = ST_PRIME_NEXT;
            ST_PRIME_NEXT:
                if (sts.divisible)
                begin
                    fail_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_PRIME_CHK;
            ST_EXP_INIT:
            begin
                sq_phase_next = 1'b0;
                state_next    = ST_EXP_NEXT;
            end
            ST_EXP_NEXT:
                if (sts.exp_zero)
                begin
                    if (idx_reg == 2'd3)
                        state_next = ST_DONE;
                    else
                        state_next = ST_EXP_INIT;
                    idx_next = idx_reg + 1'b1;
                end
                else
                    state_next = ST_EXP_MUL;
            ST_EXP_MUL:
                state_next = ST_EXP_WAIT;
            ST_EXP_WAIT:
                if (!sts.mod_busy)
                begin
                    if (!sq_phase_reg && sts.exp_bit)
                    begin
                        sq_phase_next = 1'b1;
                        state_next    = ST_EXP_MUL;
                    end
                    else
                    begin
                        sq_phase_next = 1'b0;
                        state_next    = ST_EXP_NEXT;
                    end
                end
            ST_DONE:
                if (finish)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.mod_op  = MOD_DIVCHK;
        cmd.exp_sel = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load     = in_valid;
                cmd.div_init = in_valid;
            end
            ST_PRIME_CHK:
                if (!sts.small_p && !sts.div_over)
                begin
                    cmd.mod_start = 1'b1;
                    cmd.div_start = 1'b1;
                end
            ST_PRIME_NEXT:
                cmd.div_step = 1'b1;
            ST_EXP_INIT:
                cmd.exp_init = 1'b1;
            ST_EXP_NEXT:
                cmd.save_result = sts.exp_zero;
            ST_EXP_MUL:
            begin
                cmd.mod_start = 1'b1;
                cmd.mod_op    = (sts.exp_bit && !sq_phase_reg) ? MOD_ACC : MOD_SQ;
            end
            ST_EXP_WAIT:
            begin
                cmd.mod_op    = (sts.exp_bit && !sq_phase_reg) ? MOD_ACC : MOD_SQ;
                cmd.exp_shift = !sts.mod_busy;
            end
            ST_DONE:
            begin
                cmd.out_load     = finish;
                cmd.clear_result = fail_reg;
            end
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            sq_phase_reg <= 1'b0;
            fail_reg     <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            sq_phase_reg <= sq_phase_next;
            fail_reg     <= fail_next;
            ov_reg       <= ov_next;
        end
    end

endmodule

// File: hw/rtl/dh_key_exchange_modexp_unit.sv
// Modular exponentiation key exchange unit: trial-division prime test, then four modexps.
// Trial divisors run up to sqrt(p), one remainder pass each; then each exponent bit takes one
// or two passes of the shared multiply and remainder unit.
// One request at a time; the result register frees the unit while it waits.
// Reset (rst_n low, asynchronous) returns the controller to idle and drops out_valid.
`timescale 1ns / 1ps

module dh_key_exchange_modexp_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OPERAND_WIDTH-1:0] generator,
    input  logic [OPERAND_WIDTH-1:0] modulus,
    input  logic [OPERAND_WIDTH-1:0] secret_a,
    input  logic [OPERAND_WIDTH-1:0] secret_b,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [OPERAND_WIDTH-1:0] public_a,
    output logic [OPERAND_WIDTH-1:0] public_b,
    output logic [OPERAND_WIDTH-1:0] key_one,
    output logic [OPERAND_WIDTH-1:0] key_two,
    output logic                     not_prime
);

    import dhke_pkg::*;

    dhke_cmd_t cmd;
    dhke_sts_t sts;

    dhke_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dhke_datapath #(.W(OPERAND_WIDTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .generator (generator),
        .modulus   (modulus),
        .secret_a  (secret_a),
        .secret_b  (secret_b),
        .public_a  (public_a),
        .public_b  (public_b),
        .key_one   (key_one),
        .key_two   (key_two),
        .not_prime (not_prime)
    );

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> in_ready)
        else $error("operands loaded outside idle");

    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result shown without load");

    a_no_new_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted while busy");

endmodule

// File: test/dhke_result_checker.sv
// Checker for the key exchange unit: predicts each result from the accepted request.
// Compares every accepted result field by field; depends on nothing but its ports.
`timescale 1ns / 1ps

module dhke_result_checker #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [OPERAND_WIDTH-1:0] generator,
    input  logic [OPERAND_WIDTH-1:0] modulus,
    input  logic [OPERAND_WIDTH-1:0] secret_a,
    input  logic [OPERAND_WIDTH-1:0] secret_b,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [OPERAND_WIDTH-1:0] public_a,
    input  logic [OPERAND_WIDTH-1:0] public_b,
    input  logic [OPERAND_WIDTH-1:0] key_one,
    input  logic [OPERAND_WIDTH-1:0] key_two,
    input  logic                     not_prime,
    output int                       fail_count,
    output int                       pending
);

    typedef struct {
        logic [OPERAND_WIDTH-1:0] pub_a;
        logic [OPERAND_WIDTH-1:0] pub_b;
        logic [OPERAND_WIDTH-1:0] k_one;
        logic [OPERAND_WIDTH-1:0] k_two;
        logic                     composite;
    } exchange_t;

    exchange_t exchange_q[$];

    function automatic bit prime_modulus(logic [63:0] p);
        logic [63:0] d;
        if (p < 2)
            return 0;
        for (d = 2; d * d <= p; d++)
            if (p % d == 0)
                return 0;
        return 1;
    endfunction

    function automatic logic [63:0] power_mod(logic [63:0] base, logic [63:0] ex,
                                              logic [63:0] p);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 1 % p;
        sq  = base % p;
        while (ex != 0)
        begin
            if (ex[0])
                acc = (acc * sq) % p;
            sq = (sq * sq) % p;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    function automatic exchange_t predict_exchange(logic [63:0] g, logic [63:0] p,
                                                   logic [63:0] a, logic [63:0] b);
        exchange_t r;
        logic [63:0] pa;
        logic [63:0] pb;
        logic [63:0] k1;
        logic [63:0] k2;
        r = '{default: '0};
        if (!prime_modulus(p))
        begin
            r.composite = 1'b1;
            return r;
        end
        pa = power_mod(g, a, p);
        pb = power_mod(g, b, p);
        k1 = power_mod(pb, a, p);
        k2 = power_mod(pa, b, p);
        r.pub_a = pa[OPERAND_WIDTH-1:0];
        r.pub_b = pb[OPERAND_WIDTH-1:0];
        r.k_one = k1[OPERAND_WIDTH-1:0];
        r.k_two = k2[OPERAND_WIDTH-1:0];
        return r;
    endfunction

    assign pending = exchange_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        exchange_t e;
        if (!rst_n)
        begin
            fail_count = 0;
            exchange_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                exchange_q.push_back(predict_exchange(64'(generator), 64'(modulus),
                                                      64'(secret_a), 64'(secret_b)));
            if (out_valid && out_ready)
            begin
                if (exchange_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    e = exchange_q.pop_front();
                    if (public_a !== e.pub_a)
                    begin
                        $error("public_a expected %0d actual %0d", e.pub_a, public_a);
                        fail_count++;
                    end
                    if (public_b !== e.pub_b)
                    begin
                        $error("public_b expected %0d actual %0d", e.pub_b, public_b);
                        fail_count++;
                    end
                    if (key_one !== e.k_one)
                    begin
                        $error("key_one expected %0d actual %0d", e.k_one, key_one);
                        fail_count++;
                    end
                    if (key_two !== e.k_two)
                    begin
                        $error("key_two expected %0d actual %0d", e.k_two, key_two);
                        fail_count++;
                    end
                    if (not_prime !== e.composite)
                    begin
                        $error("not_prime expected %0d actual %0d", e.composite, not_prime);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// File: test/tb_dh_key_exchange_modexp_unit.sv
// Top of the key exchange unit testbench: clock, reset, request stimulus, output back-pressure and verdict.
// Depends on dh_key_exchange_modexp_unit and dhke_result_checker.
`timescale 1ns / 1ps

module tb_dh_key_exchange_modexp_unit;

    localparam int W          = 16;
    localparam int STALL_MAX  = 400000;
    localparam int N_RANDOM   = 100;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    logic [W-1:0] generator;
    logic [W-1:0] modulus;
    logic [W-1:0] secret_a;
    logic [W-1:0] secret_b;
    logic         out_valid;
    logic         out_ready;
    logic [W-1:0] public_a;
    logic [W-1:0] public_b;
    logic [W-1:0] key_one;
    logic [W-1:0] key_two;
    logic         not_prime;
    int           fail_count;
    int           pending;
    int           stall_cycles;
    bit           no_idle;

    int unsigned prime_pool[18] = '{2, 3, 5, 7, 11, 13, 97, 101, 251, 257, 509, 1021,
                                    4093, 8191, 16381, 32749, 65519, 65521};

    dh_key_exchange_modexp_unit #(.OPERAND_WIDTH(W)) u_dut (.*);

    dhke_result_checker #(.OPERAND_WIDTH(W)) u_checker (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 22);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_request(logic [W-1:0] g, logic [W-1:0] p,
                                logic [W-1:0] a, logic [W-1:0] b);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < 22)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        generator <= g;
        modulus   <= p;
        secret_a  <= a;
        secret_b  <= b;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        logic [W-1:0] p;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        generator    = '0;
        modulus      = '0;
        secret_a     = '0;
        secret_b     = '0;
        out_ready    = 1'b0;
        stall_cycles = 0;
        no_idle      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edge moduli, zero and full exponents, base at or above the modulus
        send_request(16'd5, 16'd0, 16'd3, 16'd4);
        send_request(16'd5, 16'd1, 16'd3, 16'd4);
        send_request(16'd1, 16'd2, 16'd1, 16'd1);
        send_request(16'd2, 16'd3, 16'd5, 16'd7);
        send_request(16'd3, 16'd4, 16'd2, 16'd2);
        send_request(16'd3, 16'd9, 16'd2, 16'd2);
        send_request(16'd7, 16'd65535, 16'd11, 16'd13);
        send_request(16'd2, 16'd65521, 16'd0, 16'd0);
        send_request(16'd0, 16'd65521, 16'd65535, 16'd65535);
        send_request(16'hFFFF, 16'd65521, 16'hFFFF, 16'h1234);
        send_request(16'd0, 16'd13, 16'd0, 16'd5);
        send_request(16'd40, 16'd13, 16'd6, 16'd15);
        send_request(16'd13, 16'd13, 16'd3, 16'd4);
        send_request(16'd5, 16'd23, 16'd6, 16'd15);
        send_request(16'd3, 16'd65519, 16'hAAAA, 16'h5555);
        send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            no_idle = (i >= 40 && i < 65);
            if ($urandom_range(0, 99) < 70)
                p = W'(prime_pool[$urandom_range(0, 17)]);
            else
                p = W'($urandom_range(0, 65535));
            send_request(W'($urandom_range(0, 65535)), p,
                         W'($urandom_range(0, 65535)), W'($urandom_range(0, 65535)));
        end
        in_valid <= 1'b0;
        no_idle  = 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
